### design/mwr_pkg.sv
// ----------------------------------------------------------------------------
// Moving-window RMS package
// Shared sizes, controller commands and datapath status for the RMS meter.
// ----------------------------------------------------------------------------
package mwr_pkg;

  // Window and sample sizing.
  localparam int WINDOW_MAX   = 8192;
  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_RESET = 4096;

  // Derived widths.
  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W  = SQ_W + ADDR_W;
  localparam int ROOT_W = SAMPLE_BITS;
  localparam int RAD_W  = 2 * SAMPLE_BITS;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_CYCLES = (SUM_W + 1) / 2;
  localparam int DIV_W      = 2 * DIV_CYCLES;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_MAX   = (DIV_CYCLES > SQRT_STEPS) ? DIV_CYCLES : SQRT_STEPS;
  localparam int CNT_W      = $clog2(STEP_MAX);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic square;
    logic update;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic load_out;
    logic cfg_wr;
  } mwr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_sample;
    logic end_of_block;
    logic div_last;
    logic sqrt_last;
    logic out_busy;
  } mwr_stat_t;

endpackage

### design/mwr_ctrl.sv
// ----------------------------------------------------------------------------
// Moving-window RMS controller
// Sequences window update, division and square root for one item at a time.
// ----------------------------------------------------------------------------
module mwr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mwr_pkg::mwr_stat_t stat,
  output mwr_pkg::mwr_cmd_t  cmd
);
  import mwr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SQUARE    = 8'b0000_0010,
    S_UPDATE    = 8'b0000_0100,
    S_DIV_INIT  = 8'b0000_1000,
    S_DIV       = 8'b0001_0000,
    S_SQRT_INIT = 8'b0010_0000,
    S_SQRT      = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   idle;

  assign idle      = (state_r == S_IDLE);
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.cfg_wr = cfg_valid;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        if (stat.has_sample) begin
          state_nxt = S_UPDATE;
        end else if (stat.end_of_block) begin
          state_nxt = S_DIV_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = stat.end_of_block ? S_DIV_INIT : S_IDLE;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait until the output register is free.
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/mwr_datapath.sv
// ----------------------------------------------------------------------------
// Moving-window RMS datapath
// Square store, running sum, radix-4 divider, bitwise square root, output.
// ----------------------------------------------------------------------------
module mwr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mwr_pkg::mwr_cmd_t                 cmd,
  output mwr_pkg::mwr_stat_t                stat,
  input  logic signed [mwr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                              in_has_sample,
  input  logic                              in_end_of_block,
  input  logic [mwr_pkg::LEN_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mwr_pkg::ROOT_W-1:0]        out_rms
);
  import mwr_pkg::*;

  // Square store; entries count as zero until the position first wraps.
  logic [SQ_W-1:0]        mem [WINDOW_MAX];
  logic [SQ_W-1:0]        rd_r;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   has_sample_r;
  logic                   eob_r;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_r;

  logic [LEN_W-1:0]       len_r;
  logic [SUM_W-1:0]       sum_r;
  logic [ADDR_W-1:0]      pos_r;
  logic                   wrapped_r;
  logic [LEN_W-1:0]       pos_inc;
  logic [SQ_W-1:0]        old_sq;
  logic [LEN_W-1:0]       cfg_len;

  logic [DIV_W-1:0]       q_r;
  logic [LEN_W-1:0]       drem_r;
  logic [DIV_W-1:0]       q_a;
  logic [LEN_W-1:0]       rem_a;
  logic [LEN_W:0]         dtrial;

  logic [RAD_W-1:0]       x_r;
  logic [ROOT_W-1:0]      root_r;
  logic [ROOT_W:0]        srem_r;
  logic [ROOT_W+2:0]      srem_t;
  logic [ROOT_W+2:0]      strial;

  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic [ROOT_W-1:0]      out_rms_r;

  assign out_valid = out_valid_r;
  assign out_rms   = out_rms_r;

  assign stat.has_sample   = has_sample_r;
  assign stat.end_of_block = eob_r;
  assign stat.div_last     = (cnt_r == CNT_W'(DIV_CYCLES - 1));
  assign stat.sqrt_last    = (cnt_r == CNT_W'(SQRT_STEPS - 1));
  assign stat.out_busy     = out_valid_r && out_stall;

  // Store read on item entry and write on window update, both at the position.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rd_r <= mem[pos_r];
    end
    if (cmd.update) begin
      mem[pos_r] <= sq_r;
    end
  end

  // Input capture and exact square of the sample magnitude.
  assign mag = sample_r[SAMPLE_BITS-1] ? (~sample_r + 1'b1) : sample_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sample_r     <= in_sample;
      has_sample_r <= in_has_sample;
      eob_r        <= in_end_of_block;
    end
    if (cmd.square) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // Window bookkeeping.
  assign pos_inc = {1'b0, pos_r} + 1'b1;
  assign old_sq  = wrapped_r ? rd_r : '0;
  assign cfg_len = (cfg_data > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_W'(WINDOW_RESET);
      sum_r     <= '0;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (cmd.cfg_wr) begin
      // A zero length is ignored; any other write restarts the window.
      if (cfg_data != '0) begin
        len_r     <= cfg_len;
        sum_r     <= '0;
        pos_r     <= '0;
        wrapped_r <= 1'b0;
      end
    end else if (cmd.update) begin
      sum_r <= sum_r - SUM_W'(old_sq) + SUM_W'(sq_r);
      if (pos_inc >= len_r) begin
        pos_r     <= '0;
        wrapped_r <= 1'b1;
      end else begin
        pos_r <= pos_inc[ADDR_W-1:0];
      end
    end
  end

  // Restoring divider, two quotient bits per cycle.
  always_comb begin
    rem_a  = drem_r;
    q_a    = q_r;
    dtrial = '0;
    for (int k = 0; k < 2; k++) begin
      dtrial = {rem_a, q_a[DIV_W-1]};
      q_a    = {q_a[DIV_W-2:0], 1'b0};
      if (dtrial >= {1'b0, len_r}) begin
        rem_a  = LEN_W'(dtrial - {1'b0, len_r});
        q_a[0] = 1'b1;
      end else begin
        rem_a = dtrial[LEN_W-1:0];
      end
    end
  end

  // Digit-by-digit square root step.
  assign srem_t = {srem_r, x_r[RAD_W-1:RAD_W-2]};
  assign strial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r    <= DIV_W'(sum_r);
      drem_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= q_a;
      drem_r <= rem_a;
    end
    if (cmd.sqrt_init) begin
      x_r    <= q_r[RAD_W-1:0];
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      x_r <= {x_r[RAD_W-3:0], 2'b00};
      if (srem_t >= strial) begin
        srem_r <= (ROOT_W+1)'(srem_t - strial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_t[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Step counter shared by the divider and the square root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_init || cmd.sqrt_init) begin
      cnt_r <= '0;
    end else if (cmd.div_step || cmd.sqrt_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register; a result waits here until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rms_r <= root_r;
    end
  end

endmodule

### design/moving_window_rms_unit.sv
// ----------------------------------------------------------------------------
// Moving-window RMS unit
// Sliding-window RMS meter for signed Q1.15 audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one sample, a has_sample
//   flag and an end_of_block flag per transaction. Each valid sample replaces
//   the oldest square in the window store and updates an exact running sum.
//   An item with end_of_block set yields one result transaction on the output
//   channel (out_valid/out_stall): floor(sqrt(sum / window_length)) as Q1.15.
//   Items are handled one at a time. A sample passes the square and window
//   update states; an item without a sample skips the update. An item that
//   asks for a result then runs the divider (2 quotient bits per cycle) and
//   the square root (1 bit per cycle) in turn, and the next item is taken
//   only after the result has been loaded into the output register.
//   The cfg channel (cfg_valid/cfg_ready) writes window_length while idle;
//   zero is ignored, values above 8192 saturate, and any other write restarts
//   the window. Reset sets window_length to 4096 and an empty window. The
//   store needs no clearing pass: entries count as zero until the write
//   position first wraps. If the receiver stalls, the result is held in the
//   output register and a following result waits in the controller.
// ----------------------------------------------------------------------------
module moving_window_rms_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [mwr_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic                                    in_has_sample,
  input  logic                                    in_end_of_block,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mwr_pkg::LEN_W-1:0]               cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [mwr_pkg::ROOT_W-1:0]              out_rms
);
  import mwr_pkg::*;

  mwr_cmd_t  cmd;
  mwr_stat_t stat;

  // Controller.
  mwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  mwr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       (in_sample),
    .in_has_sample   (in_has_sample),
    .in_end_of_block (in_end_of_block),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rms         (out_rms)
  );

endmodule
